/* design/rsa_pkg.sv */
// Package for the range selector with auto ranging: transaction payload types,
// range limits, key codes and the relay and display lookup tables.
// No dependencies.
package rsa_pkg;

    // Highest selectable range index
    localparam logic [2:0] TOP_RANGE  = 3'd6;
    // Key port value when no key is pressed (active low)
    localparam logic [7:0] IDLE_KEYS  = 8'hFF;
    // Bit forced into the display byte while auto ranging
    localparam logic [7:0] AUTO_FLAG  = 8'h01;
    // Input mode codes
    localparam logic       MODE_KEYS  = 1'b0;
    localparam logic       MODE_TICK  = 1'b1;
    // Position of the final bit within a shift-out run
    localparam logic [3:0] LAST_SLOT  = 4'd15;

    typedef struct packed {
        logic       mode;
        logic [7:0] keys;
        logic       over_range;
        logic       under_range;
    } t_in_item;

    typedef struct packed {
        logic       serial_bit;
        logic       last_bit;
        logic [2:0] range_now;
        logic       auto_now;
    } t_out_item;

    // Relay drive byte for each range
    function automatic logic [7:0] relay_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h60;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h48;
            3'd3:    v = 8'h44;
            3'd4:    v = 8'h42;
            3'd5:    v = 8'h02;
            3'd6:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Display drive byte for each range
    function automatic logic [7:0] disp_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h88;
            3'd1:    v = 8'h24;
            3'd2:    v = 8'h44;
            3'd3:    v = 8'h84;
            3'd4:    v = 8'h22;
            3'd5:    v = 8'h42;
            3'd6:    v = 8'h82;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* design/range_selector_with_autorange_top.sv */
// Range selector with auto ranging: input register, single-pass update of the
// range state, a frame holding register and a sixteen-bit output shifter.
// Depends on rsa_pkg.
//
// The first bit of a frame is offered once the transaction has passed the input
// register, holding register and shifter, given a free holding register and shifter.
// Throughput: one input transaction per cycle while no frame is produced; each range
// change yields a sixteen-bit frame sent one bit per cycle while the output is ready.
// Reset (synchronous, active low): range 0, auto ranging on, no key latched,
// all pipeline stages empty.
module range_selector_with_autorange_top
    import rsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Input register
    logic       r_in_vld;
    t_in_item   r_in;

    // Architectural state
    logic [2:0] r_range;
    logic       r_auto;
    logic [7:0] r_key_code;
    logic       r_key_pending;

    // Frame holding register
    logic        r_hold_vld;
    logic [15:0] r_hold_word;
    logic [2:0]  r_hold_range;
    logic        r_hold_auto;

    // Output shifter
    logic        r_sh_vld;
    logic [15:0] r_sh_word;
    logic [3:0]  r_cnt;
    logic [2:0]  r_sh_range;
    logic        r_sh_auto;

    // Next-state values from the update logic
    logic [2:0]  n_range;
    logic       n_auto;
    logic [7:0] n_key_code;
    logic       n_key_pending;
    logic       n_emit;
    logic [15:0] n_word;

    logic       out_fire;
    logic       sh_free;
    logic       hold_to_sh;
    logic       hold_free;
    logic       adv;

    logic [7:0] act;
    logic       single_key;
    logic [2:0] key_bit;
    logic [2:0] key_range;
    logic [7:0] disp;

    // Decode of the latched key code: a single active-low key only
    always_comb begin
        act        = ~r_key_code;
        single_key = (act != 8'h00) && ((act & (act - 8'd1)) == 8'h00);
        key_bit    = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (act[b]) begin
                key_bit = 3'(b);
            end
        end
        key_range = (key_bit == 3'd1) ? 3'd0 : (key_bit - 3'd1);
    end

    // Single-pass update of the range state for the registered transaction
    always_comb begin
        n_range       = r_range;
        n_auto        = r_auto;
        n_key_code    = r_key_code;
        n_key_pending = r_key_pending;
        n_emit        = 1'b0;
        if (r_in.mode == MODE_KEYS) begin
            if (r_key_pending) begin
                if (r_in.keys == IDLE_KEYS && single_key) begin
                    if (key_bit == 3'd0) begin
                        n_auto  = 1'b1;
                        n_range = 3'd0;
                        n_emit  = 1'b1;
                    end else if (key_range <= TOP_RANGE) begin
                        n_auto  = 1'b0;
                        n_range = key_range;
                        n_emit  = 1'b1;
                    end
                end
                n_key_pending = 1'b0;
            end
            if (r_in.keys != IDLE_KEYS) begin
                n_key_code    = r_in.keys;
                n_key_pending = 1'b1;
            end
        end else if (r_auto) begin
            if (r_in.over_range && r_range != 3'd0) begin
                n_range = r_range - 3'd1;
                n_emit  = 1'b1;
            end else if (r_in.under_range && r_range < TOP_RANGE) begin
                n_range = r_range + 3'd1;
                n_emit  = 1'b1;
            end
        end
        disp   = n_auto ? (disp_byte(n_range) | AUTO_FLAG) : disp_byte(n_range);
        n_word = {disp, relay_byte(n_range)};
    end

    // Flow control between the stages
    assign out_fire   = r_sh_vld && i_out_ready;
    assign sh_free    = !r_sh_vld || (out_fire && r_cnt == LAST_SLOT);
    assign hold_to_sh = r_hold_vld && sh_free;
    assign hold_free  = !r_hold_vld || hold_to_sh;
    assign adv        = r_in_vld && (!n_emit || hold_free);
    assign o_in_ready = !r_in_vld || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // State registers, updated when the transaction leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range       <= 3'd0;
            r_auto        <= 1'b1;
            r_key_code    <= 8'h00;
            r_key_pending <= 1'b0;
        end else if (adv) begin
            r_range       <= n_range;
            r_auto        <= n_auto;
            r_key_code    <= n_key_code;
            r_key_pending <= n_key_pending;
        end
    end

    // Frame holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
        end else if (adv && n_emit) begin
            r_hold_vld <= 1'b1;
        end else if (hold_to_sh) begin
            r_hold_vld <= 1'b0;
        end
        if (adv && n_emit) begin
            r_hold_word  <= n_word;
            r_hold_range <= n_range;
            r_hold_auto  <= n_auto;
        end
    end

    // Output shifter, LSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_vld <= 1'b0;
            r_cnt    <= 4'd0;
        end else if (hold_to_sh) begin
            r_sh_vld <= 1'b1;
            r_cnt    <= 4'd0;
        end else if (out_fire) begin
            if (r_cnt == LAST_SLOT) begin
                r_sh_vld <= 1'b0;
            end
            r_cnt <= r_cnt + 4'd1;
        end
        if (hold_to_sh) begin
            r_sh_word  <= r_hold_word;
            r_sh_range <= r_hold_range;
            r_sh_auto  <= r_hold_auto;
        end else if (out_fire) begin
            r_sh_word <= {1'b0, r_sh_word[15:1]};
        end
    end

    // Output transaction
    assign o_out_valid           = r_sh_vld;
    assign o_out_data.serial_bit = r_sh_word[0];
    assign o_out_data.last_bit   = (r_cnt == LAST_SLOT);
    assign o_out_data.range_now  = r_sh_range;
    assign o_out_data.auto_now   = r_sh_auto;

endmodule
